// ===== sv/slm_pkg.sv =====
// ----------------------------------------------------------------------------
// slm_pkg
// Shared types and constants of the sorted list merge core.
// ----------------------------------------------------------------------------
package slm_pkg;

   localparam int VALUE_W = 32;

   typedef enum logic [1:0] {
      REQ_LOAD_FIRST  = 2'd0,
      REQ_LOAD_SECOND = 2'd1,
      REQ_RUN         = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_FETCH,
      BK_MERGE
   } back_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   typedef struct packed {
      logic busy;
   } back_status_type;

endpackage

// ===== sv/slm_req_if.sv =====
// ----------------------------------------------------------------------------
// slm_req_if
// Request channel: list loads and run commands.
// ----------------------------------------------------------------------------
interface slm_req_if;
   import slm_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [1:0]                req_type;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, req_type, value, input ready);
   modport sink   (input valid, req_type, value, output ready);
endinterface

// ===== sv/slm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// slm_rsp_if
// Result channel: merged elements in ascending order.
// ----------------------------------------------------------------------------
interface slm_rsp_if;
   import slm_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] merged_value;
   logic                      from_second;
   logic                      is_last;
   logic                      is_empty;

   modport source (output valid, merged_value, from_second, is_last, is_empty,
                   input ready);
   modport sink   (input valid, merged_value, from_second, is_last, is_empty,
                   output ready);
endinterface

// ===== sv/sorted_list_merge_core.sv =====
// ----------------------------------------------------------------------------
// sorted_list_merge_core
// Two-way merge of two ascending lists of signed 32-bit values.
// ----------------------------------------------------------------------------
// req_chan carries loads into the first or second list and run commands.
// A load writes the next entry of its buffer; loads into a full list are
// dropped. A run emits the merged ascending sequence on rsp_chan, first
// list winning ties, with is_last on the final element and a single
// is_empty result when both lists were empty. Counts clear on run.
// Run commands wait in a two-entry queue; loads stall while a merge is
// queued or running, since it still reads the buffers.
// Each merged element passes through BK_FETCH, which addresses both buffer
// RAMs, then BK_MERGE, which compares the registered heads. A run command
// reaches the output register through the queue, BK_FETCH and BK_MERGE; an
// is_empty result for empty lists goes from the queue into that register.
// The output register holds a result while rsp_chan.ready is low; the merge
// then pauses without losing state. Reset clears the counts, the queue and
// the output valid; buffer contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_list_merge_core #(
   parameter int MAX_LEN = 32
) (
   input logic        clock,
   input logic        reset,
   slm_req_if.sink    req_chan,
   slm_rsp_if.source  rsp_chan
);
   import slm_pkg::*;

   localparam int CNT_W  = $clog2(MAX_LEN + 1);
   localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   fifo_status_type     fifo_status;
   back_status_type     back_status;
   logic                push, pop;
   logic [2*CNT_W-1:0]  push_data, pop_data;
   logic                wr1_en, wr2_en;
   logic [ADDR_W-1:0]   wr1_addr, wr2_addr, rd1_addr, rd2_addr;
   logic [VALUE_W-1:0]  wr_data, rd1_data, rd2_data;

   slm_front #(.MAX_LEN(MAX_LEN), .CNT_W(CNT_W), .ADDR_W(ADDR_W)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .back_status (back_status),
      .fifo_status (fifo_status),
      .push        (push),
      .push_data   (push_data),
      .wr1_en      (wr1_en),
      .wr1_addr    (wr1_addr),
      .wr2_en      (wr2_en),
      .wr2_addr    (wr2_addr),
      .wr_data     (wr_data)
   );

   slm_run_fifo #(.WIDTH(2 * CNT_W), .DEPTH(2)) u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_data   (push_data),
      .pop         (pop),
      .pop_data    (pop_data),
      .fifo_status (fifo_status)
   );

   slm_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_LEN), .ADDR_W(ADDR_W)) u_ram1 (
      .clock   (clock),
      .wr_en   (wr1_en),
      .wr_addr (wr1_addr),
      .wr_data (wr_data),
      .rd_addr (rd1_addr),
      .rd_data (rd1_data)
   );

   slm_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_LEN), .ADDR_W(ADDR_W)) u_ram2 (
      .clock   (clock),
      .wr_en   (wr2_en),
      .wr_addr (wr2_addr),
      .wr_data (wr_data),
      .rd_addr (rd2_addr),
      .rd_data (rd2_data)
   );

   slm_back #(.MAX_LEN(MAX_LEN), .CNT_W(CNT_W), .ADDR_W(ADDR_W)) u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_status (fifo_status),
      .pop_data    (pop_data),
      .pop         (pop),
      .rd1_addr    (rd1_addr),
      .rd1_data    (rd1_data),
      .rd2_addr    (rd2_addr),
      .rd2_data    (rd2_data),
      .back_status (back_status),
      .rsp_chan    (rsp_chan)
   );

   a_no_write_during_merge: assert property (@(posedge clock) disable iff (reset)
      (wr1_en || wr2_en) |-> (!back_status.busy && fifo_status.empty))
      else $error("buffer written while a merge is pending");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !fifo_status.full)
      else $error("run queue overflow");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !fifo_status.empty)
      else $error("run queue underflow");

   a_empty_result_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.is_empty) |->
         (rsp_chan.is_last && !rsp_chan.from_second && (rsp_chan.merged_value == '0)))
      else $error("malformed empty-run result");

endmodule

// ===== sv/slm_ram.sv =====
// ----------------------------------------------------------------------------
// slm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module slm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/slm_run_fifo.sv =====
// ----------------------------------------------------------------------------
// slm_run_fifo
// Short queue of run commands, each carrying the two list lengths.
// ----------------------------------------------------------------------------
module slm_run_fifo #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [WIDTH-1:0]         push_data,
   input  logic                     pop,
   output logic [WIDTH-1:0]         pop_data,
   output slm_pkg::fifo_status_type fifo_status
);
   import slm_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data          = data_ff[rd_ptr_ff];
   assign fifo_status.full  = (count_ff == CNT_W'(DEPTH));
   assign fifo_status.empty = (count_ff == '0);

endmodule

// ===== sv/slm_front.sv =====
// ----------------------------------------------------------------------------
// slm_front
// Request decode: appends loads to the list buffers, queues run commands.
// ----------------------------------------------------------------------------
module slm_front #(
   parameter int MAX_LEN = 32,
   parameter int CNT_W = $clog2(MAX_LEN + 1),
   parameter int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   slm_req_if.sink                    req_chan,
   input  slm_pkg::back_status_type   back_status,
   input  slm_pkg::fifo_status_type   fifo_status,
   output logic                       push,
   output logic [2*CNT_W-1:0]         push_data,
   output logic                       wr1_en,
   output logic [ADDR_W-1:0]          wr1_addr,
   output logic                       wr2_en,
   output logic [ADDR_W-1:0]          wr2_addr,
   output logic [slm_pkg::VALUE_W-1:0] wr_data
);
   import slm_pkg::*;

   logic [CNT_W-1:0] cnt1_ff, cnt1_in;
   logic [CNT_W-1:0] cnt2_ff, cnt2_in;
   logic             is_load;
   logic             is_run;
   logic             accept;

   assign is_load = (req_chan.req_type == REQ_LOAD_FIRST) ||
                    (req_chan.req_type == REQ_LOAD_SECOND);
   assign is_run  = (req_chan.req_type == REQ_RUN);

   // loads wait until no merge is pending or running on the buffers
   assign req_chan.ready = is_run  ? !fifo_status.full :
                           is_load ? (!back_status.busy && fifo_status.empty) :
                                     1'b1;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      cnt1_in = cnt1_ff;
      cnt2_in = cnt2_ff;
      wr1_en  = 1'b0;
      wr2_en  = 1'b0;
      push    = 1'b0;
      if (accept) begin
         unique case (req_chan.req_type)
            REQ_LOAD_FIRST: begin
               if (cnt1_ff < CNT_W'(MAX_LEN)) begin
                  wr1_en  = 1'b1;
                  cnt1_in = cnt1_ff + CNT_W'(1);
               end
            end
            REQ_LOAD_SECOND: begin
               if (cnt2_ff < CNT_W'(MAX_LEN)) begin
                  wr2_en  = 1'b1;
                  cnt2_in = cnt2_ff + CNT_W'(1);
               end
            end
            REQ_RUN: begin
               push    = 1'b1;
               cnt1_in = '0;
               cnt2_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt1_ff <= '0;
         cnt2_ff <= '0;
      end else begin
         cnt1_ff <= cnt1_in;
         cnt2_ff <= cnt2_in;
      end
   end

   assign push_data = {cnt1_ff, cnt2_ff};
   assign wr1_addr  = cnt1_ff[ADDR_W-1:0];
   assign wr2_addr  = cnt2_ff[ADDR_W-1:0];
   assign wr_data   = req_chan.value;

endmodule

// ===== sv/slm_back.sv =====
// ----------------------------------------------------------------------------
// slm_back
// Merge engine: walks both buffers and emits the merged ascending sequence.
// ----------------------------------------------------------------------------
module slm_back #(
   parameter int MAX_LEN = 32,
   parameter int CNT_W = $clog2(MAX_LEN + 1),
   parameter int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  slm_pkg::fifo_status_type    fifo_status,
   input  logic [2*CNT_W-1:0]          pop_data,
   output logic                        pop,
   output logic [ADDR_W-1:0]           rd1_addr,
   input  logic [slm_pkg::VALUE_W-1:0] rd1_data,
   output logic [ADDR_W-1:0]           rd2_addr,
   input  logic [slm_pkg::VALUE_W-1:0] rd2_data,
   output slm_pkg::back_status_type    back_status,
   slm_rsp_if.source                   rsp_chan
);
   import slm_pkg::*;

   localparam int SUM_W = CNT_W + 1;

   back_state_type            state_ff, state_in;
   logic [CNT_W-1:0]          n1_ff, n1_in, n2_ff, n2_in;
   logic [CNT_W-1:0]          p1_ff, p1_in, p2_ff, p2_in;
   logic [SUM_W-1:0]          left_ff, left_in;
   logic                      out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0]        out_value_ff, out_value_in;
   logic                      out_second_ff, out_second_in;
   logic                      out_last_ff, out_last_in;
   logic                      out_empty_ff, out_empty_in;
   logic                      out_free;
   logic                      take_first;
   logic [CNT_W-1:0]          q_n1, q_n2;

   assign q_n1     = pop_data[2*CNT_W-1:CNT_W];
   assign q_n2     = pop_data[CNT_W-1:0];
   assign out_free = !out_valid_ff || rsp_chan.ready;

   assign take_first = (p1_ff < n1_ff) &&
                       ((p2_ff >= n2_ff) || ($signed(rd1_data) <= $signed(rd2_data)));

   always_comb begin
      state_in      = state_ff;
      n1_in         = n1_ff;
      n2_in         = n2_ff;
      p1_in         = p1_ff;
      p2_in         = p2_ff;
      left_in       = left_ff;
      pop           = 1'b0;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_value_in  = out_value_ff;
      out_second_in = out_second_ff;
      out_last_in   = out_last_ff;
      out_empty_in  = out_empty_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!fifo_status.empty) begin
               if ((q_n1 == '0) && (q_n2 == '0)) begin
                  if (out_free) begin
                     pop           = 1'b1;
                     out_valid_in  = 1'b1;
                     out_value_in  = '0;
                     out_second_in = 1'b0;
                     out_last_in   = 1'b1;
                     out_empty_in  = 1'b1;
                  end
               end else begin
                  pop      = 1'b1;
                  n1_in    = q_n1;
                  n2_in    = q_n2;
                  p1_in    = '0;
                  p2_in    = '0;
                  left_in  = SUM_W'(q_n1) + SUM_W'(q_n2);
                  state_in = BK_FETCH;
               end
            end
         end
         BK_FETCH: begin
            state_in = BK_MERGE;
         end
         BK_MERGE: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_empty_in  = 1'b0;
               out_last_in   = (left_ff == SUM_W'(1));
               out_second_in = !take_first;
               if (take_first) begin
                  out_value_in = rd1_data;
                  p1_in        = p1_ff + CNT_W'(1);
               end else begin
                  out_value_in = rd2_data;
                  p2_in        = p2_ff + CNT_W'(1);
               end
               left_in  = left_ff - SUM_W'(1);
               state_in = (left_ff == SUM_W'(1)) ? BK_IDLE : BK_FETCH;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n1_ff         <= n1_in;
      n2_ff         <= n2_in;
      p1_ff         <= p1_in;
      p2_ff         <= p2_in;
      left_ff       <= left_in;
      out_value_ff  <= out_value_in;
      out_second_ff <= out_second_in;
      out_last_ff   <= out_last_in;
      out_empty_ff  <= out_empty_in;
   end

   assign rd1_addr         = p1_ff[ADDR_W-1:0];
   assign rd2_addr         = p2_ff[ADDR_W-1:0];
   assign back_status.busy = (state_ff != BK_IDLE);

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.merged_value = out_value_ff;
   assign rsp_chan.from_second  = out_second_ff;
   assign rsp_chan.is_last      = out_last_ff;
   assign rsp_chan.is_empty     = out_empty_ff;

endmodule
